// ----- sv/dpb_pkg.sv -----
// Shared constants, register indexes and controller/datapath interface types.
`default_nettype none
package dpb_pkg;

   localparam int MAX_WIDTH  = 4096;
   localparam int CNT_W      = $clog2(MAX_WIDTH);
   localparam int FW_W       = 13;
   localparam int INV_W      = 24;
   localparam int INV_HALF_W = INV_W / 2;
   localparam int CTR_W      = 16;
   localparam int DEPTH_W    = 16;
   localparam int OUT_W      = 24;
   localparam int SUB_SHIFT  = 4;
   localparam int FRAC_SHIFT = 28;
   localparam int PZ_W       = CTR_W + DEPTH_W;
   localparam int PP_W       = PZ_W + INV_HALF_W;
   localparam int SUM_W      = PZ_W + INV_W + 1;
   localparam int RND_W      = SUM_W - FRAC_SHIFT;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [CSR_ADDR_W-1:0] REG_INV_FOCAL_X = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_INV_FOCAL_Y = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_CENTER_X    = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_CENTER_Y    = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_FRAME_WIDTH = 3'd4;

   localparam logic [INV_W-1:0] INV_FOCAL_RESET   = 24'd33554;
   localparam logic [CTR_W-1:0] CENTER_X_RESET    = 16'd5120;
   localparam logic [CTR_W-1:0] CENTER_Y_RESET    = 16'd3840;
   localparam logic [FW_W-1:0]  FRAME_WIDTH_RESET = 13'd640;

   typedef struct packed {
      logic load;      // accept a pixel beat, advance counters
      logic mul_z;     // offset magnitude times depth
      logic mul_lo;    // times low half of reciprocal
      logic mul_hi;    // times high half of reciprocal
      logic rnd;       // combine, round, saturate
      logic sel_y;     // 0: x coordinate, 1: y coordinate
      logic out_load;  // move finished point into output registers
   } dpb_cmd_type;

   typedef struct packed {
      logic depth_nonzero;
   } dpb_stat_type;

endpackage
`default_nettype wire

// ----- sv/dpb_ctrl.sv -----
// Sequencer for the back-projection datapath and output valid tracking.
`default_nettype none
module dpb_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   input  wire dpb_pkg::dpb_stat_type stat,
   output dpb_pkg::dpb_cmd_type     cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MZ   = 3'd1;
   localparam logic [2:0] ST_LO   = 3'd2;
   localparam logic [2:0] ST_HI   = 3'd3;
   localparam logic [2:0] ST_RND  = 3'd4;
   localparam logic [2:0] ST_OUT  = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       sel_y_ff, sel_y_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;
   logic       out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      sel_y_in = sel_y_ff;
      cmd      = '0;
      cmd.sel_y = sel_y_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load = accept;
            if (accept && stat.depth_nonzero) begin
               state_in = ST_MZ;
               sel_y_in = 1'b0;
            end
         end
         ST_MZ: begin
            cmd.mul_z = 1'b1;
            state_in  = ST_LO;
         end
         ST_LO: begin
            cmd.mul_lo = 1'b1;
            state_in   = ST_HI;
         end
         ST_HI: begin
            cmd.mul_hi = 1'b1;
            state_in   = ST_RND;
         end
         ST_RND: begin
            cmd.rnd = 1'b1;
            if (sel_y_ff) begin
               state_in = ST_OUT;
            end else begin
               state_in = ST_MZ;
               sel_y_in = 1'b1;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sel_y_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sel_y_ff     <= sel_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // A finished point never overwrites one still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("output overwritten while beat pending");

   a_start_x: assert property (@(posedge clock) disable iff (reset)
      (accept && stat.depth_nonzero) |=> (state_ff == ST_MZ && !sel_y_ff))
      else $error("nonzero pixel did not start with x");

   a_out_after_y: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) |-> sel_y_ff)
      else $error("output reached before y was computed");

   a_valid_follows_load: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid_ff)
      else $error("loaded point not presented");

endmodule
`default_nettype wire

// ----- sv/dpb_datapath.sv -----
// Config registers, pixel counters, shared multiplier chain and output registers.
`default_nettype none
module dpb_datapath (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire dpb_pkg::dpb_cmd_type                   cmd,
   output dpb_pkg::dpb_stat_type                       stat,
   input  wire logic                                   csr_we,
   input  wire logic [dpb_pkg::CSR_ADDR_W-1:0]         csr_addr,
   input  wire logic [dpb_pkg::CSR_DATA_W-1:0]         csr_wdata,
   input  wire logic [dpb_pkg::DEPTH_W-1:0]            req_depth_raw,
   input  wire logic                                   req_frame_start,
   output logic signed [dpb_pkg::OUT_W-1:0]            rsp_point_x,
   output logic signed [dpb_pkg::OUT_W-1:0]            rsp_point_y,
   output logic [dpb_pkg::DEPTH_W-1:0]                 rsp_point_z
);

   localparam int CNT_W = dpb_pkg::CNT_W;
   localparam int FW_W  = dpb_pkg::FW_W;

   logic [dpb_pkg::INV_W-1:0]  inv_focal_x_ff, inv_focal_y_ff;
   logic [dpb_pkg::CTR_W-1:0]  center_x_ff, center_y_ff;
   logic [FW_W-1:0]            frame_width_ff;

   logic [CNT_W-1:0]           col_ff, col_in, row_ff, row_in;
   logic [CNT_W-1:0]           col_base, row_base;
   logic [FW_W-1:0]            eff_width;
   logic [FW_W-1:0]            col_next;

   logic [CNT_W-1:0]           u_ff, v_ff;
   logic [dpb_pkg::DEPTH_W-1:0] depth_ff;

   logic [CNT_W-1:0]           pos;
   logic [dpb_pkg::CTR_W-1:0]  center;
   logic [dpb_pkg::INV_W-1:0]  inv;
   logic [dpb_pkg::CTR_W-1:0]  scaled;
   logic                       neg;
   logic [dpb_pkg::CTR_W-1:0]  mag;

   logic                       neg_ff;
   logic [dpb_pkg::PZ_W-1:0]   pz_ff;
   logic [dpb_pkg::PP_W-1:0]   pp_ff;
   logic [dpb_pkg::PP_W-1:0]   acc_lo_ff;

   logic [dpb_pkg::SUM_W-1:0]  sum;
   logic [dpb_pkg::RND_W-1:0]  rmag;
   logic [dpb_pkg::OUT_W-1:0]  res;
   logic [dpb_pkg::OUT_W-1:0]  res_x_ff, res_y_ff;

   localparam logic [dpb_pkg::RND_W-1:0] POS_LIMIT =
      dpb_pkg::RND_W'((1 << (dpb_pkg::OUT_W - 1)) - 1);
   localparam logic [dpb_pkg::RND_W-1:0] NEG_LIMIT =
      dpb_pkg::RND_W'(1 << (dpb_pkg::OUT_W - 1));
   localparam logic [dpb_pkg::SUM_W-1:0] HALF =
      dpb_pkg::SUM_W'(1) << (dpb_pkg::FRAC_SHIFT - 1);

   assign stat.depth_nonzero = (req_depth_raw != '0);

   // Config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         inv_focal_x_ff <= dpb_pkg::INV_FOCAL_RESET;
         inv_focal_y_ff <= dpb_pkg::INV_FOCAL_RESET;
         center_x_ff    <= dpb_pkg::CENTER_X_RESET;
         center_y_ff    <= dpb_pkg::CENTER_Y_RESET;
         frame_width_ff <= dpb_pkg::FRAME_WIDTH_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            dpb_pkg::REG_INV_FOCAL_X: inv_focal_x_ff <= csr_wdata[dpb_pkg::INV_W-1:0];
            dpb_pkg::REG_INV_FOCAL_Y: inv_focal_y_ff <= csr_wdata[dpb_pkg::INV_W-1:0];
            dpb_pkg::REG_CENTER_X:    center_x_ff    <= csr_wdata[dpb_pkg::CTR_W-1:0];
            dpb_pkg::REG_CENTER_Y:    center_y_ff    <= csr_wdata[dpb_pkg::CTR_W-1:0];
            dpb_pkg::REG_FRAME_WIDTH: frame_width_ff <= csr_wdata[FW_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Raster position: clamp width to [1, MAX_WIDTH]
   always_comb begin
      priority if (frame_width_ff == '0) begin
         eff_width = FW_W'(1);
      end else if (frame_width_ff > FW_W'(dpb_pkg::MAX_WIDTH)) begin
         eff_width = FW_W'(dpb_pkg::MAX_WIDTH);
      end else begin
         eff_width = frame_width_ff;
      end
      col_base = req_frame_start ? '0 : col_ff;
      row_base = req_frame_start ? '0 : row_ff;
      col_next = FW_W'(col_base) + FW_W'(1);
      if (col_next >= eff_width) begin
         col_in = '0;
         row_in = row_base + CNT_W'(1);
      end else begin
         col_in = col_next[CNT_W-1:0];
         row_in = row_base;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (cmd.load) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         u_ff     <= col_base;
         v_ff     <= row_base;
         depth_ff <= req_depth_raw;
      end
   end

   // Shared arithmetic for x and y
   always_comb begin
      pos    = cmd.sel_y ? v_ff : u_ff;
      center = cmd.sel_y ? center_y_ff : center_x_ff;
      inv    = cmd.sel_y ? inv_focal_y_ff : inv_focal_x_ff;
      scaled = {pos, dpb_pkg::SUB_SHIFT'(0)};
      neg    = scaled < center;
      mag    = neg ? (center - scaled) : (scaled - center);
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_z) begin
         neg_ff <= neg;
         pz_ff  <= dpb_pkg::PZ_W'(mag) * dpb_pkg::PZ_W'(depth_ff);
      end
      if (cmd.mul_lo) begin
         pp_ff <= dpb_pkg::PP_W'(pz_ff) * dpb_pkg::PP_W'(inv[dpb_pkg::INV_HALF_W-1:0]);
      end
      if (cmd.mul_hi) begin
         acc_lo_ff <= pp_ff;
         pp_ff <= dpb_pkg::PP_W'(pz_ff) *
                  dpb_pkg::PP_W'(inv[dpb_pkg::INV_W-1:dpb_pkg::INV_HALF_W]);
      end
   end

   // Sum partials, round half away from zero on the magnitude, saturate
   always_comb begin
      sum  = dpb_pkg::SUM_W'(acc_lo_ff)
           + (dpb_pkg::SUM_W'(pp_ff) << dpb_pkg::INV_HALF_W)
           + HALF;
      rmag = sum[dpb_pkg::SUM_W-1:dpb_pkg::FRAC_SHIFT];
      if (neg_ff) begin
         if (rmag > NEG_LIMIT) begin
            res = NEG_LIMIT[dpb_pkg::OUT_W-1:0];
         end else begin
            res = dpb_pkg::OUT_W'(0) - rmag[dpb_pkg::OUT_W-1:0];
         end
      end else begin
         if (rmag > POS_LIMIT) begin
            res = POS_LIMIT[dpb_pkg::OUT_W-1:0];
         end else begin
            res = rmag[dpb_pkg::OUT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rnd) begin
         if (cmd.sel_y) begin
            res_y_ff <= res;
         end else begin
            res_x_ff <= res;
         end
      end
      if (cmd.out_load) begin
         rsp_point_x <= res_x_ff;
         rsp_point_y <= res_y_ff;
         rsp_point_z <= depth_ff;
      end
   end

endmodule
`default_nettype wire

// ----- sv/depth_pixel_backprojection.sv -----
// Top level: depth pixel stream in, millimetre 3D points out.
//
// req_* carries one depth pixel per beat (valid/ready) in raster order; a set
// req_frame_start places that pixel at column 0, row 0. Column wraps at the
// configured frame width (0 acts as 1, above 4096 acts as 4096).
// rsp_* carries one point per nonzero-depth pixel; zero-depth pixels advance
// the counters and produce no beat.
// csr_* writes a register at any edge with csr_we high; write only while idle.
// A nonzero pixel, once accepted, runs an x pass and then a y pass through
// the one shared 16x16 / 32x12 multiplier chain (2 x 4 steps: MZ, LO, HI,
// RND), then is moved into the output registers, which raises rsp_valid.
// req_ready stays low until that output load, so the block takes no new
// pixel meanwhile; a zero-depth pixel leaves req_ready high.
// A finished point waits in the output register; the next pixel is accepted
// meanwhile, but its point is held back until the waiting beat is taken.
// Reset (synchronous) clears counters, restores register defaults and empties
// the output.
`default_nettype none
module depth_pixel_backprojection (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic [dpb_pkg::DEPTH_W-1:0]            req_depth_raw,
   input  wire logic                                   req_frame_start,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic signed [dpb_pkg::OUT_W-1:0]            rsp_point_x,
   output logic signed [dpb_pkg::OUT_W-1:0]            rsp_point_y,
   output logic [dpb_pkg::DEPTH_W-1:0]                 rsp_point_z,
   input  wire logic                                   csr_we,
   input  wire logic [dpb_pkg::CSR_ADDR_W-1:0]         csr_addr,
   input  wire logic [dpb_pkg::CSR_DATA_W-1:0]         csr_wdata
);

   dpb_pkg::dpb_cmd_type  cmd;
   dpb_pkg::dpb_stat_type stat;

   dpb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   dpb_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .csr_we          (csr_we),
      .csr_addr        (csr_addr),
      .csr_wdata       (csr_wdata),
      .req_depth_raw   (req_depth_raw),
      .req_frame_start (req_frame_start),
      .rsp_point_x     (rsp_point_x),
      .rsp_point_y     (rsp_point_y),
      .rsp_point_z     (rsp_point_z)
   );

endmodule
`default_nettype wire

// ----- tb/depth_pixel_backprojection_tb.sv -----
// Testbench for depth_pixel_backprojection: a directed table, then random configs and frames.
module depth_pixel_backprojection_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CSR_ADDR_W = dpb_pkg::CSR_ADDR_W;
   localparam int CSR_DATA_W = dpb_pkg::CSR_DATA_W;
   localparam int DEPTH_W    = dpb_pkg::DEPTH_W;
   localparam int OUT_W      = dpb_pkg::OUT_W;
   localparam int INV_W      = dpb_pkg::INV_W;
   localparam int CTR_W      = dpb_pkg::CTR_W;
   localparam int FW_W       = dpb_pkg::FW_W;
   localparam int CNT_W      = dpb_pkg::CNT_W;
   localparam int MAX_WIDTH  = dpb_pkg::MAX_WIDTH;
   localparam int FRAC_SHIFT = dpb_pkg::FRAC_SHIFT;

   // indexes with no register behind them; writes there must be ignored
   localparam logic [CSR_ADDR_W-1:0] REG_SPARE_LO = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] REG_SPARE_HI = 3'd7;

   localparam int          SETTLE_CYCLES = 14;
   localparam int          RANDOM_PHASES = 12;
   localparam int          PHASE_ITEMS   = 150;
   localparam logic [63:0] ROUND_HALF    = 64'd1 << (FRAC_SHIFT - 1);
   localparam logic [63:0] SAT_POS       = 64'd8388607;
   localparam logic [63:0] SAT_NEG_MAG   = 64'd8388608;

   typedef struct packed {
      logic signed [OUT_W-1:0] x;
      logic signed [OUT_W-1:0] y;
      logic [DEPTH_W-1:0]      z;
   } cloud_point_type;

   typedef struct packed {
      logic                  is_csr;
      logic [CSR_ADDR_W-1:0] addr;
      logic [CSR_DATA_W-1:0] data;
      logic [DEPTH_W-1:0]    depth;
      logic                  fs;
      logic                  literal;
      cloud_point_type       pt;
   } plan_row_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [DEPTH_W-1:0]      req_depth_raw = '0;
   logic                    req_frame_start = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b1;
   logic signed [OUT_W-1:0] rsp_point_x;
   logic signed [OUT_W-1:0] rsp_point_y;
   logic [DEPTH_W-1:0]      rsp_point_z;
   logic                    csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0]   csr_addr = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;

   // camera model state
   logic [INV_W-1:0]   cam_inv_x, cam_inv_y;
   logic [CTR_W-1:0]   cam_cx, cam_cy;
   logic [FW_W-1:0]    cam_width;
   logic [CNT_W-1:0]   col_pos, row_pos;

   cloud_point_type expected_points[$];
   plan_row_type    plan[$];
   logic            literal_on = 1'b0;
   cloud_point_type literal_point = '0;
   logic            burst_mode = 1'b0;
   int              stall_left = 0;
   int              error_count = 0;
   logic            pix_made;
   cloud_point_type pix_point, want_point;

   depth_pixel_backprojection dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_depth_raw   (req_depth_raw),
      .req_frame_start (req_frame_start),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_point_x     (rsp_point_x),
      .rsp_point_y     (rsp_point_y),
      .rsp_point_z     (rsp_point_z),
      .csr_we          (csr_we),
      .csr_addr        (csr_addr),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("depth_pixel_backprojection_tb: errors");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      error_count++;
   endtask

   task automatic reset_camera;
      cam_inv_x = 24'd33554;
      cam_inv_y = 24'd33554;
      cam_cx    = 16'd5120;
      cam_cy    = 16'd3840;
      cam_width = 13'd640;
      col_pos   = '0;
      row_pos   = '0;
   endtask

   task automatic apply_register(input logic [CSR_ADDR_W-1:0] addr,
                                 input logic [CSR_DATA_W-1:0] data);
      case (addr)
         dpb_pkg::REG_INV_FOCAL_X: cam_inv_x = data[INV_W-1:0];
         dpb_pkg::REG_INV_FOCAL_Y: cam_inv_y = data[INV_W-1:0];
         dpb_pkg::REG_CENTER_X:    cam_cx    = data[CTR_W-1:0];
         dpb_pkg::REG_CENTER_Y:    cam_cy    = data[CTR_W-1:0];
         dpb_pkg::REG_FRAME_WIDTH: cam_width = data[FW_W-1:0];
         default: ;
      endcase
   endtask

   // offset in sixteenths times depth times reciprocal, rounded half away, saturated
   function automatic logic [OUT_W-1:0] project_axis(input logic [CNT_W-1:0] pos,
                                                     input logic [CTR_W-1:0] center,
                                                     input logic [INV_W-1:0] inv,
                                                     input logic [DEPTH_W-1:0] z);
      logic [CTR_W-1:0] scaled, diff;
      logic             neg;
      logic [63:0]      r;
      scaled = {pos, 4'b0000};
      neg    = scaled < center;
      diff   = neg ? center - scaled : scaled - center;
      r      = (64'(diff) * 64'(z) * 64'(inv) + ROUND_HALF) >> FRAC_SHIFT;
      if (neg) begin
         if (r > SAT_NEG_MAG) r = SAT_NEG_MAG;
         r = -r;
      end else if (r > SAT_POS) begin
         r = SAT_POS;
      end
      return r[OUT_W-1:0];
   endfunction

   task automatic place_pixel(input logic [DEPTH_W-1:0] depth, input logic fs,
                              output logic made, output cloud_point_type pt);
      logic [FW_W-1:0]  w;
      logic [CNT_W-1:0] u, v;
      w = cam_width;
      if (w == 0) w = 13'd1;
      if (w > MAX_WIDTH) w = 13'(MAX_WIDTH);
      if (fs) begin
         col_pos = '0;
         row_pos = '0;
      end
      u = col_pos;
      v = row_pos;
      // a column already past a lowered width wraps on this advance
      if ({1'b0, col_pos} + 13'd1 >= w) begin
         col_pos = '0;
         row_pos = row_pos + 1'b1;
      end else begin
         col_pos = col_pos + 1'b1;
      end
      made = depth != 0;
      pt.x = project_axis(u, cam_cx, cam_inv_x, depth);
      pt.y = project_axis(v, cam_cy, cam_inv_y, depth);
      pt.z = depth;
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            place_pixel(req_depth_raw, req_frame_start, pix_made, pix_point);
            if (pix_made)
               expected_points.insert(expected_points.size(),
                                      literal_on ? literal_point : pix_point);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_points.size() == 0) begin
               report_mismatch("point beat with nothing outstanding");
            end else begin
               want_point = expected_points.pop_front();
               if (rsp_point_x !== want_point.x)
                  report_mismatch($sformatf("point_x %0d, want %0d", rsp_point_x, want_point.x));
               if (rsp_point_y !== want_point.y)
                  report_mismatch($sformatf("point_y %0d, want %0d", rsp_point_y, want_point.y));
               if (rsp_point_z !== want_point.z)
                  report_mismatch($sformatf("point_z %0d, want %0d", rsp_point_z, want_point.z));
            end
         end
      end
   end

   // mostly zero, sometimes short, rarely long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   always @(negedge clock) begin
      if (reset || burst_mode) begin
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left = stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
         stall_left = pick_gap();
      end
   end

   function automatic plan_row_type pixel_row(input logic [DEPTH_W-1:0] depth, input logic fs);
      plan_row_type r;
      r = '0;
      r.depth = depth;
      r.fs = fs;
      return r;
   endfunction

   function automatic plan_row_type known_row(input logic [DEPTH_W-1:0] depth, input logic fs,
                                              input logic signed [OUT_W-1:0] x,
                                              input logic signed [OUT_W-1:0] y);
      plan_row_type r;
      r = pixel_row(depth, fs);
      r.literal = 1'b1;
      r.pt.x = x;
      r.pt.y = y;
      r.pt.z = depth;
      return r;
   endfunction

   function automatic plan_row_type csr_row(input logic [CSR_ADDR_W-1:0] addr,
                                            input logic [CSR_DATA_W-1:0] data);
      plan_row_type r;
      r = '0;
      r.is_csr = 1'b1;
      r.addr = addr;
      r.data = data;
      return r;
   endfunction

   task automatic add_row(input plan_row_type r);
      plan.insert(plan.size(), r);
   endtask

   // called at a falling edge; returns at the falling edge after the beat
   task automatic send_pixel(input logic [DEPTH_W-1:0] depth, input logic fs,
                             input logic lit, input cloud_point_type lit_pt);
      int gap;
      gap = burst_mode ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      literal_on = lit;
      literal_point = lit_pt;
      req_valid <= 1'b1;
      req_depth_raw <= depth;
      req_frame_start <= fs;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // drain outstanding points, then let any zero-depth pixel finish
   task automatic settle;
      req_valid <= 1'b0;
      while (expected_points.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= data;
      apply_register(addr, data);
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [CSR_DATA_W-1:0] pick_inverse();
      case ($urandom_range(0, 4))
         0: return '0;
         1: return '1;
         2: return CSR_DATA_W'($urandom_range(20000, 70000));
         default: return CSR_DATA_W'($urandom);
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_center();
      logic [CTR_W-1:0] c;
      case ($urandom_range(0, 4))
         0: c = '0;
         1: c = '1;
         2: c = CTR_W'($urandom_range(0, 2048));
         default: c = CTR_W'($urandom);
      endcase
      return {8'($urandom), c};
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_width();
      logic [FW_W-1:0] w;
      case ($urandom_range(0, 7))
         0: w = '0;
         1: w = 13'd1;
         2: w = 13'd2;
         3: w = 13'($urandom_range(3, 24));
         4: w = 13'd640;
         5: w = 13'(MAX_WIDTH);
         6: w = 13'($urandom_range(MAX_WIDTH + 1, 8191));
         default: w = 13'($urandom_range(25, MAX_WIDTH - 1));
      endcase
      return {11'($urandom), w};
   endfunction

   function automatic logic [DEPTH_W-1:0] pick_depth();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) return '0;
      if (r < 25) return '1;
      if (r < 35) return DEPTH_W'($urandom_range(1, 15));
      return DEPTH_W'($urandom);
   endfunction

   initial begin : stimulus
      int           idx, ph, n;
      plan_row_type row;
      reset_camera();

      add_row(known_row(16'd1000, 1'b1, -24'sd640, -24'sd480));
      add_row(pixel_row(16'd0, 1'b0));
      add_row(pixel_row(16'hFFFF, 1'b0));
      add_row(pixel_row(16'd1, 1'b0));
      add_row(csr_row(dpb_pkg::REG_INV_FOCAL_X, 24'd0));
      add_row(csr_row(dpb_pkg::REG_INV_FOCAL_Y, 24'd0));
      add_row(known_row(16'd1, 1'b1, 24'sd0, 24'sd0));
      add_row(known_row(16'hFFFF, 1'b0, 24'sd0, 24'sd0));
      add_row(csr_row(dpb_pkg::REG_INV_FOCAL_X, 24'hFFFFFF));
      add_row(csr_row(dpb_pkg::REG_INV_FOCAL_Y, 24'hFFFFFF));
      add_row(csr_row(dpb_pkg::REG_CENTER_X, 24'h00FFFF));
      add_row(csr_row(dpb_pkg::REG_CENTER_Y, 24'h00FFFF));
      add_row(known_row(16'hFFFF, 1'b1, -24'sd8388608, -24'sd8388608));
      add_row(csr_row(dpb_pkg::REG_CENTER_X, 24'd0));
      add_row(csr_row(dpb_pkg::REG_CENTER_Y, 24'd0));
      add_row(known_row(16'hFFFF, 1'b1, 24'sd0, 24'sd0));
      add_row(pixel_row(16'd0, 1'b0));
      // width zero acts as one; column is already past it
      add_row(csr_row(dpb_pkg::REG_FRAME_WIDTH, 24'd0));
      add_row(pixel_row(16'd7, 1'b0));
      add_row(pixel_row(16'd7, 1'b0));
      add_row(pixel_row(16'd7, 1'b0));
      add_row(csr_row(dpb_pkg::REG_FRAME_WIDTH, 24'h001FFF));
      add_row(pixel_row(16'd300, 1'b1));
      add_row(pixel_row(16'd300, 1'b0));
      add_row(csr_row(dpb_pkg::REG_FRAME_WIDTH, 24'd1));
      add_row(pixel_row(16'd300, 1'b0));
      add_row(csr_row(dpb_pkg::REG_INV_FOCAL_X, 24'd33554));
      add_row(csr_row(dpb_pkg::REG_INV_FOCAL_Y, 24'd33554));
      add_row(csr_row(dpb_pkg::REG_CENTER_X, 24'd5120));
      add_row(csr_row(dpb_pkg::REG_CENTER_Y, 24'd3840));
      add_row(csr_row(dpb_pkg::REG_FRAME_WIDTH, 24'd640));
      add_row(csr_row(REG_SPARE_LO, 24'hFFFFFF));
      add_row(csr_row(REG_SPARE_HI, 24'd0));
      add_row(known_row(16'd1000, 1'b1, -24'sd640, -24'sd480));
      add_row(pixel_row(16'd0, 1'b0));

      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (idx = 0; idx < plan.size(); idx++) begin
         row = plan[idx];
         if (row.is_csr) begin
            settle();
            write_csr(row.addr, row.data);
         end else begin
            send_pixel(row.depth, row.fs, row.literal, row.pt);
         end
      end

      for (ph = 0; ph < RANDOM_PHASES; ph++) begin
         burst_mode <= (ph % 4 == 3);
         settle();
         write_csr(dpb_pkg::REG_INV_FOCAL_X, pick_inverse());
         write_csr(dpb_pkg::REG_INV_FOCAL_Y, pick_inverse());
         write_csr(dpb_pkg::REG_CENTER_X, pick_center());
         write_csr(dpb_pkg::REG_CENTER_Y, pick_center());
         write_csr(dpb_pkg::REG_FRAME_WIDTH, pick_width());
         if ($urandom_range(0, 2) == 0)
            write_csr($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, CSR_DATA_W'($urandom));
         for (n = 0; n < PHASE_ITEMS; n++) begin
            // hold the sender until the pipe is empty
            if (n == PHASE_ITEMS / 2 && ph % 3 == 1) settle();
            send_pixel(pick_depth(), $urandom_range(0, 49) == 0, 1'b0, '0);
         end
      end

      settle();
      if (error_count == 0)
         $display("depth_pixel_backprojection_tb: clean");
      else
         $display("depth_pixel_backprojection_tb: errors");
      $finish;
   end

endmodule
